@@ rtl/core/isbi_pkg.sv @@
package isbi_pkg;

  // Default ring depth and reset value of the retention window.
  localparam int DEPTH_DEFAULT = 32;
  localparam logic [47:0] RETENTION_RESET = 48'd1000000;

  // Number of motion axes per sample and the fixed-point scale.
  localparam int NUM_AXES = 6;
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // A trim never leaves fewer than this many samples; coverage needs more.
  localparam int MIN_KEEP = 2;

  // Command codes.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TRIM  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_NO_END   = 2'd2;

  typedef logic [NUM_AXES-1:0][31:0] motion_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [47:0]        timestamp;
    logic [47:0]        window_end;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [47:0]        out_timestamp;
    logic signed [31:0] out_accel_x;
    logic signed [31:0] out_accel_y;
    logic signed [31:0] out_accel_z;
    logic signed [31:0] out_gyro_x;
    logic signed [31:0] out_gyro_y;
    logic signed [31:0] out_gyro_z;
    logic               is_interpolated;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    SRC_INTERP,
    SRC_STORED,
    SRC_NO_START
  } src_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_Q_RDF,
    S_Q_RDB,
    S_Q_CHK,
    S_Q_DEC,
    S_LOC_RD,
    S_LOC_CHK,
    S_DIV,
    S_BLEND,
    S_PUSH_INT,
    S_WALK_RD,
    S_WALK_CHK,
    S_END,
    S_FLUSH
  } isbi_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_ITER
  } isbi_div_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    mem_wr;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_front;
    logic    cap_cov;
    logic    idx_clr;
    logic    idx_inc;
    logic    cap_prev;
    logic    pop;
    logic    div_start;
    logic    blend_start;
    logic    push;
    src_t    push_src;
    logic    flush;
    logic    tgt_end;
  } isbi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       trim_hit;
    logic       cov_s;
    logic       cov_e;
    logic       loc_adv;
    logic       idx_lt_cnt;
    logic       walk_ok;
    logic       div_done;
    logic       blend_done;
    logic       can_push;
    logic       out_free;
  } isbi_stat_t;

endpackage

@@ rtl/core/isbi_div.sv @@
module isbi_div
  import isbi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] t,
  input  logic [47:0] t0,
  input  logic [47:0] t1,
  output logic        done,
  output logic [16:0] quo
);

  isbi_div_state_t state, state_next;

  logic [47:0] num;
  logic [47:0] den;
  logic        ok;
  logic [47:0] rem;
  logic [FRAC_BITS-1:0] q;
  logic [3:0]  cnt;

  logic [48:0] rem_sh;
  logic        ge;
  logic [47:0] rem_next;
  logic [FRAC_BITS-1:0] q_next;

  // One quotient bit per cycle by restoring division.
  assign rem_sh   = {rem, 1'b0};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? 48'(rem_sh - {1'b0, den}) : rem_sh[47:0];
  assign q_next   = {q[FRAC_BITS-2:0], ge};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = DIV_PREP;
        end
      end
      DIV_PREP: begin
        if (!ok || num >= den) begin
          state_next = DIV_IDLE;
        end else begin
          state_next = DIV_ITER;
        end
      end
      DIV_ITER: begin
        if (cnt == 4'(FRAC_BITS - 1)) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  // Done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == DIV_PREP) && (!ok || num >= den)) ||
              ((state == DIV_ITER) && (cnt == 4'(FRAC_BITS - 1)));
    end
  end

  // Operands, partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= t - t0;
      den <= t1 - t0;
      ok  <= (t1 > t0) && (t >= t0);
    end
    if (state == DIV_PREP) begin
      rem <= num;
      q   <= '0;
      cnt <= '0;
      if (!ok) begin
        quo <= '0;
      end else if (num >= den) begin
        quo <= ONE_Q16;
      end
    end else if (state == DIV_ITER) begin
      rem <= rem_next;
      q   <= q_next;
      cnt <= cnt + 4'd1;
      if (cnt == 4'(FRAC_BITS - 1)) begin
        quo <= {1'b0, q_next};
      end
    end
  end

endmodule

@@ rtl/core/isbi_dp.sv @@
module isbi_dp
  import isbi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_item,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  input  isbi_cmd_t   cmd,
  output isbi_stat_t  stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Ring storage.
  logic [47:0] time_mem   [DEPTH];
  motion_t     motion_mem [DEPTH];

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [47:0]   rw;
  in_item_t      req;

  logic [47:0] rd_time;
  motion_t     rd_motion;
  logic [47:0] front_time;
  logic [47:0] prev_time;
  motion_t     prev_motion;
  logic        cov_s;
  logic        cov_e;

  logic [47:0]   tgt;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          full;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign tgt  = cmd.tgt_end ? req.window_end : req.timestamp;
  assign full = (count == CW'(DEPTH));

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_FRONT: rd_addr = head;
      RD_BACK:  rd_addr = slot_of(head, (count == '0) ? '0 : count - CW'(1));
      RD_IDX:   rd_addr = slot_of(head, idx);
      default:  rd_addr = head;
    endcase
  end

  // A full ring overwrites the oldest slot.
  assign wr_addr = full ? head : slot_of(head, count);

  // Ring memories with registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      time_mem[wr_addr]   <= req.timestamp;
      motion_mem[wr_addr] <= {req.gyro_z, req.gyro_y, req.gyro_x,
                              req.accel_z, req.accel_y, req.accel_x};
    end
    if (cmd.rd_en) begin
      rd_time   <= time_mem[rd_addr];
      rd_motion <= motion_mem[rd_addr];
    end
  end

  // Ring pointers, scan index and retention register.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
      rw    <= RETENTION_RESET;
    end else begin
      if (cfg_we) begin
        rw <= cfg_wdata;
      end
      if (cmd.mem_wr) begin
        if (full) begin
          head <= slot_of(head, CW'(1));
        end else begin
          count <= count + CW'(1);
        end
      end else if (cmd.pop) begin
        head  <= slot_of(head, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // Request latch and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req <= in_item;
    end
    if (cmd.cap_front) begin
      front_time <= rd_time;
    end
    if (cmd.cap_cov) begin
      cov_s <= (count > CW'(MIN_KEEP)) && (front_time < req.timestamp) &&
               (req.timestamp < rd_time);
      cov_e <= (count > CW'(MIN_KEEP)) && (front_time < req.window_end) &&
               (req.window_end < rd_time);
    end
    if (cmd.cap_prev) begin
      prev_time   <= rd_time;
      prev_motion <= rd_motion;
    end
  end

  // Interpolation factor.
  logic        div_done;
  logic [16:0] factor;

  isbi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .t     (tgt),
    .t0    (prev_time),
    .t1    (rd_time),
    .done  (div_done),
    .quo   (factor)
  );

  // Blend one axis per cycle: a + floor(f * (b - a) / 2^16).
  logic [2:0]         bl_cnt;
  logic               bl_run;
  logic [2:0]         bl_ax;
  logic signed [32:0] bl_diff;
  logic signed [50:0] bl_prod;
  logic               s1_valid;
  logic [2:0]         s1_ax;
  logic signed [31:0] s1_a;
  logic signed [50:0] s1_prod;
  logic signed [34:0] s2_sum;
  motion_t            blend_res;

  assign bl_ax   = (bl_cnt == 3'(NUM_AXES)) ? '0 : bl_cnt;
  assign bl_diff = $signed({rd_motion[bl_ax][31], rd_motion[bl_ax]}) -
                   $signed({prev_motion[bl_ax][31], prev_motion[bl_ax]});
  assign bl_prod = $signed({1'b0, factor}) * bl_diff;
  assign s2_sum  = 35'(s1_a) + 35'(s1_prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_run   <= 1'b0;
      bl_cnt   <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= bl_run && (bl_cnt < 3'(NUM_AXES));
      if (cmd.blend_start) begin
        bl_run <= 1'b1;
        bl_cnt <= '0;
      end else if (bl_run) begin
        bl_cnt <= bl_cnt + 3'd1;
        if (bl_cnt == 3'(NUM_AXES)) begin
          bl_run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ax   <= bl_ax;
    s1_a    <= $signed(prev_motion[bl_ax]);
    s1_prod <= bl_prod;
    if (s1_valid) begin
      blend_res[s1_ax] <= s2_sum[31:0];
    end
  end

  // Result assembly.
  out_item_t new_item;
  logic [47:0] new_ts;
  motion_t     new_mo;
  logic        hold_valid;
  out_item_t   hold_item;
  out_item_t   last_item;
  logic        out_free;

  always_comb begin
    new_ts = '0;
    new_mo = '0;
    new_item = '0;
    unique case (cmd.push_src)
      SRC_INTERP: begin
        new_ts = tgt;
        new_mo = blend_res;
        new_item.is_interpolated = 1'b1;
      end
      SRC_STORED: begin
        new_ts = rd_time;
        new_mo = rd_motion;
      end
      default: begin
        new_ts = '0;
        new_mo = '0;
      end
    endcase
    new_item.out_timestamp = new_ts;
    new_item.out_accel_x   = $signed(new_mo[0]);
    new_item.out_accel_y   = $signed(new_mo[1]);
    new_item.out_accel_z   = $signed(new_mo[2]);
    new_item.out_gyro_x    = $signed(new_mo[3]);
    new_item.out_gyro_y    = $signed(new_mo[4]);
    new_item.out_gyro_z    = $signed(new_mo[5]);
    if (cmd.push_src == SRC_NO_START) begin
      new_item.status = ST_NO_START;
    end else begin
      new_item.status = cov_e ? ST_OK : ST_NO_END;
    end
    new_item.last = 1'b0;
  end

  // The held result marked as the final one of its query.
  always_comb begin
    last_item      = hold_item;
    last_item.last = 1'b1;
  end

  // One result is held back until it is known whether it is the last.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.push && hold_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hold_item <= new_item;
      if (hold_valid) begin
        out_item <= hold_item;
      end
    end else if (cmd.flush) begin
      out_item <= last_item;
    end
  end

  // Status to the controller.
  always_comb begin
    stat            = '0;
    stat.req_cmd    = in_item.cmd;
    stat.trim_hit   = (count > CW'(MIN_KEEP)) &&
                      (({1'b0, rd_time} + {1'b0, rw}) < {1'b0, req.timestamp});
    stat.cov_s      = cov_s;
    stat.cov_e      = cov_e;
    stat.idx_lt_cnt = idx < count;
    stat.loc_adv    = (idx < count) && (rd_time <= tgt);
    stat.walk_ok    = rd_time < req.window_end;
    stat.div_done   = div_done;
    stat.blend_done = s1_valid && (s1_ax == 3'(NUM_AXES - 1));
    stat.can_push   = !hold_valid || out_free;
    stat.out_free   = out_free;
  end

  // Checks on the ring and the result hand-off.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("Sample count exceeds the ring depth.");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.push && hold_valid) |-> out_free)
    else $error("Held result pushed over an untaken result.");
  assert property (@(posedge clk) disable iff (rst) cmd.flush |-> hold_valid)
    else $error("Flush without a held result.");
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (count >= CW'(MIN_KEEP)))
    else $error("Trim left fewer samples than the minimum.");

endmodule

@@ rtl/core/isbi_ctrl.sv @@
module isbi_ctrl
  import isbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  isbi_stat_t stat,
  output isbi_cmd_t  cmd
);

  isbi_state_t state, state_next;
  logic        phase_end, phase_end_next;

  // State register; phase_end marks the end-bound half of a query.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_end <= 1'b0;
    end else begin
      state     <= state_next;
      phase_end <= phase_end_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    phase_end_next = phase_end;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.tgt_end    = phase_end;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (stat.req_cmd)
            CMD_ADD:   state_next = S_ADD;
            CMD_TRIM:  state_next = S_TRIM_RD;
            CMD_QUERY: state_next = S_Q_RDF;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd.mem_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_TRIM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FRONT;
        state_next = S_TRIM_CHK;
      end
      S_TRIM_CHK: begin
        if (stat.trim_hit) begin
          cmd.pop    = 1'b1;
          state_next = S_TRIM_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_Q_RDF: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FRONT;
        state_next = S_Q_RDB;
      end
      S_Q_RDB: begin
        cmd.cap_front = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_BACK;
        state_next    = S_Q_CHK;
      end
      S_Q_CHK: begin
        cmd.cap_cov = 1'b1;
        state_next  = S_Q_DEC;
      end
      S_Q_DEC: begin
        if (stat.cov_s) begin
          cmd.idx_clr    = 1'b1;
          phase_end_next = 1'b0;
          state_next     = S_LOC_RD;
        end else if (stat.can_push) begin
          cmd.push     = 1'b1;
          cmd.push_src = SRC_NO_START;
          state_next   = S_FLUSH;
        end
      end
      S_LOC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_next = S_LOC_CHK;
      end
      S_LOC_CHK: begin
        if (stat.loc_adv) begin
          cmd.cap_prev = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_next   = S_LOC_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.blend_start = 1'b1;
          state_next      = S_BLEND;
        end
      end
      S_BLEND: begin
        if (stat.blend_done) begin
          state_next = S_PUSH_INT;
        end
      end
      S_PUSH_INT: begin
        if (stat.can_push) begin
          cmd.push     = 1'b1;
          cmd.push_src = SRC_INTERP;
          state_next   = phase_end ? S_FLUSH : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_WALK_CHK;
        end else begin
          state_next = S_END;
        end
      end
      S_WALK_CHK: begin
        if (!stat.walk_ok) begin
          state_next = S_END;
        end else if (stat.can_push) begin
          cmd.push     = 1'b1;
          cmd.push_src = SRC_STORED;
          cmd.idx_inc  = 1'b1;
          state_next   = S_WALK_RD;
        end
      end
      S_END: begin
        if (stat.cov_e) begin
          cmd.idx_clr    = 1'b1;
          phase_end_next = 1'b1;
          state_next     = S_LOC_RD;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/imu_sample_buffer_interpolator_unit.sv @@
// Time-ordered ring of up to DEPTH IMU samples with add, trim and interval query requests.
// An add writes one sample. A trim removes samples from the front one by one, bounded by
// the single read port of the ring. A query reads the front and back samples, then
// scans the ring from the front to find each bound, and interpolates each covered bound
// with a bit-serial divider (which skips its iterations when the factor saturates) and a
// one-axis-per-cycle blender; stored samples in the interval follow. Stalls on the output
// side lengthen a query. A new request is taken whenever the unit is idle, even if the
// final result of the previous query still waits at the output.
module imu_sample_buffer_interpolator_unit
  import isbi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata
);

  isbi_cmd_t  cmd;
  isbi_stat_t stat;

  // Sequencer.
  isbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring, interpolation and result registers.
  isbi_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ test/tb_imu_sample_buffer_interpolator_unit.sv @@
module tb_imu_sample_buffer_interpolator_unit;
  import isbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 4 * RING + 100;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [47:0] cfg_wdata;

  // Shadow copy of the sample ring and the retention register.
  logic [47:0] ring_time [RING];
  logic [31:0] ring_motion [RING][6];
  int unsigned ring_head;
  int unsigned ring_count;
  logic [47:0] window_reg;

  out_item_t   pending_samples[$];
  int          error_count;
  int          request_count;
  int          result_count;
  int          query_count;
  int          idle_cycles;
  bit          random_ready;

  imu_sample_buffer_interpolator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot(int unsigned i);
    return (ring_head + i) % RING;
  endfunction

  function automatic logic [47:0] time_of(int unsigned i);
    return ring_time[slot(i)];
  endfunction

  function automatic bit is_covered(logic [47:0] t);
    return ring_count > 2 && time_of(0) < t && t < time_of(ring_count - 1);
  endfunction

  // First sample, in ring order, whose time is beyond t.
  function automatic int unsigned upper_index(logic [47:0] t);
    int unsigned i;
    i = 0;
    while (i < ring_count && time_of(i) <= t) i++;
    return i;
  endfunction

  function automatic logic [16:0] blend_factor(logic [47:0] num, logic [47:0] den);
    logic [63:0] q;
    if (num >= den) return ONE_Q16;
    q = ({16'd0, num} << 16) / {16'd0, den};
    return q[16:0];
  endfunction

  function automatic logic [31:0] mix(logic signed [31:0] a, logic signed [31:0] b,
                                      logic [16:0] f);
    logic signed [63:0] acc;
    acc = $signed({47'd0, ONE_Q16 - f}) * 64'(a) + $signed({47'd0, f}) * 64'(b);
    return 32'(acc >>> 16);
  endfunction

  function automatic out_item_t interp_sample(logic [47:0] t);
    out_item_t   r;
    int unsigned k;
    int unsigned p;
    logic [16:0] f;
    logic [31:0] v [6];
    k = upper_index(t);
    if (k == 0 || k >= ring_count) k = 1;
    p = k - 1;
    f = (time_of(k) > time_of(p) && t >= time_of(p)) ?
        blend_factor(t - time_of(p), time_of(k) - time_of(p)) : 17'd0;
    for (int ax = 0; ax < 6; ax++)
      v[ax] = mix(ring_motion[slot(p)][ax], ring_motion[slot(k)][ax], f);
    r = '0;
    r.out_timestamp = t;
    {r.out_accel_x, r.out_accel_y, r.out_accel_z} = {v[0], v[1], v[2]};
    {r.out_gyro_x, r.out_gyro_y, r.out_gyro_z} = {v[3], v[4], v[5]};
    r.is_interpolated = 1'b1;
    return r;
  endfunction

  // Updates the shadow ring for one request and queues the samples it returns.
  task automatic predict_samples(in_item_t it);
    out_item_t   run[$];
    out_item_t   r;
    int unsigned s;
    logic [1:0]  st;
    case (it.cmd)
      CMD_ADD: begin
        if (ring_count >= RING) begin
          ring_head = (ring_head + 1) % RING;
          ring_count = RING - 1;
        end
        s = slot(ring_count);
        ring_time[s] = it.timestamp;
        ring_motion[s] = '{it.accel_x, it.accel_y, it.accel_z,
                           it.gyro_x, it.gyro_y, it.gyro_z};
        ring_count++;
      end
      CMD_TRIM: begin
        while (ring_count > 2 && 49'(time_of(0)) + 49'(window_reg) < 49'(it.timestamp)) begin
          ring_head = (ring_head + 1) % RING;
          ring_count--;
        end
      end
      CMD_QUERY: begin
        query_count++;
        if (!is_covered(it.timestamp)) begin
          r = '0;
          r.status = ST_NO_START;
          r.last = 1'b1;
          pending_samples = {pending_samples, r};
        end else begin
          run = {run, interp_sample(it.timestamp)};
          for (int unsigned i = upper_index(it.timestamp);
               i < ring_count && time_of(i) < it.window_end; i++) begin
            s = slot(i);
            r = '0;
            r.out_timestamp = ring_time[s];
            {r.out_accel_x, r.out_accel_y, r.out_accel_z} =
              {ring_motion[s][0], ring_motion[s][1], ring_motion[s][2]};
            {r.out_gyro_x, r.out_gyro_y, r.out_gyro_z} =
              {ring_motion[s][3], ring_motion[s][4], ring_motion[s][5]};
            run = {run, r};
          end
          if (is_covered(it.window_end)) begin
            run = {run, interp_sample(it.window_end)};
            st = ST_OK;
          end else begin
            st = ST_NO_END;
          end
          foreach (run[k]) begin
            run[k].status = st;
            run[k].last = (k == run.size() - 1);
            pending_samples = {pending_samples, run[k]};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Result checker and output-side stall generator.
  initial begin
    out_item_t want;
    int        gap;
    out_ready = 1'b0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready && !rst) begin
        result_count++;
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_item.out_timestamp), 64'd0);
        end else begin
          want = pending_samples[0];
          pending_samples.delete(0);
          if (out_item.out_timestamp !== want.out_timestamp)
            report_mismatch("out_timestamp", 64'(out_item.out_timestamp),
                            64'(want.out_timestamp));
          if (out_item.out_accel_x !== want.out_accel_x)
            report_mismatch("out_accel_x", 64'(out_item.out_accel_x), 64'(want.out_accel_x));
          if (out_item.out_accel_y !== want.out_accel_y)
            report_mismatch("out_accel_y", 64'(out_item.out_accel_y), 64'(want.out_accel_y));
          if (out_item.out_accel_z !== want.out_accel_z)
            report_mismatch("out_accel_z", 64'(out_item.out_accel_z), 64'(want.out_accel_z));
          if (out_item.out_gyro_x !== want.out_gyro_x)
            report_mismatch("out_gyro_x", 64'(out_item.out_gyro_x), 64'(want.out_gyro_x));
          if (out_item.out_gyro_y !== want.out_gyro_y)
            report_mismatch("out_gyro_y", 64'(out_item.out_gyro_y), 64'(want.out_gyro_y));
          if (out_item.out_gyro_z !== want.out_gyro_z)
            report_mismatch("out_gyro_z", 64'(out_item.out_gyro_z), 64'(want.out_gyro_z));
          if (out_item.is_interpolated !== want.is_interpolated)
            report_mismatch("is_interpolated", 64'(out_item.is_interpolated),
                            64'(want.is_interpolated));
          if (out_item.status !== want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
          if (out_item.last !== want.last)
            report_mismatch("last", 64'(out_item.last), 64'(want.last));
        end
        gap = random_ready ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no handshake happens.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_samples.size());
        $display("** imu_sample_buffer_interpolator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Sends one request after a random gap and predicts its samples. Valid stays high
  // after the handshake until the next gap or the next drain takes it down.
  task automatic send_request(in_item_t it, bit with_gap = 1'b1);
    int gap;
    gap = with_gap ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_samples(it);
    request_count++;
  endtask

  function automatic in_item_t make_add(logic [47:0] t);
    in_item_t it;
    it = '0;
    it.cmd = CMD_ADD;
    it.timestamp = t;
    it.window_end = 48'({$urandom, $urandom});
    {it.accel_x, it.accel_y, it.accel_z} = {$urandom, $urandom, $urandom};
    {it.gyro_x, it.gyro_y, it.gyro_z} = {$urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] c, logic [47:0] t, logic [47:0] e);
    in_item_t it;
    it = make_add(t);
    it.cmd = c;
    it.window_end = e;
    return it;
  endfunction

  // Waits for every outstanding result, then lets the unit finish any trim.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [47:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = value;
  endtask

  // Directed: extremes of values, every command, uncovered bounds, trims.
  task automatic test_directed();
    in_item_t it;
    send_request(make_cmd(CMD_QUERY, 48'd5, 48'd10));
    it = make_add(48'd0);
    {it.accel_x, it.accel_y, it.accel_z} = {32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    {it.gyro_x, it.gyro_y, it.gyro_z} = {32'h7fff_ffff, 32'h8000_0000, 32'h0};
    send_request(it);
    it = make_add(48'd1000);
    {it.accel_x, it.accel_y, it.accel_z} = {32'h7fff_ffff, 32'h8000_0000, 32'h0};
    {it.gyro_x, it.gyro_y, it.gyro_z} = {32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    send_request(it);
    send_request(make_cmd(CMD_QUERY, 48'd500, 48'd600));
    send_request(make_add(48'd3000));
    send_request(make_add(48'd7001));
    send_request(make_cmd(CMD_QUERY, 48'd1, 48'd6999));
    send_request(make_cmd(CMD_QUERY, 48'd999, 48'd7001));
    send_request(make_cmd(CMD_QUERY, 48'd2000, 48'd100));
    send_request(make_cmd(CMD_QUERY, 48'd0, 48'd500));
    send_request(make_cmd(CMD_QUERY, 48'd1000, 48'hffff_ffff_ffff));
    send_request(make_cmd(2'd3, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff));
    send_request(make_cmd(CMD_TRIM, 48'd10, 48'd0));
    send_request(make_add(48'hffff_ffff_fffe));
    send_request(make_cmd(CMD_QUERY, 48'hffff_ffff_fff0, 48'hffff_ffff_ffff));
    send_request(make_cmd(CMD_TRIM, 48'hffff_ffff_ffff, 48'd0));
    send_request(make_cmd(CMD_QUERY, 48'd7002, 48'd7003));
  endtask

  // Fills past capacity so that the oldest samples are overwritten.
  task automatic test_ring_wrap();
    for (int i = 0; i < RING + 3; i++) send_request(make_add(48'(i * 50 + 100)));
    send_request(make_cmd(CMD_QUERY, 48'd300, 48'd1500));
    send_request(make_cmd(CMD_QUERY, 48'd101, 48'd1870));
  endtask

  // Random add streams with queries, trims and invalid commands, mostly time-ordered.
  task automatic test_random(int n);
    logic [47:0] now;
    logic [47:0] a;
    logic [47:0] b;
    int          pick;
    now = 48'({$urandom_range(0, 255), 40'd0}) | 48'($urandom);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        now = now + 48'($urandom_range(1, 5000));
        if ($urandom_range(0, 15) == 0) now = 48'({$urandom, $urandom});
        send_request(make_add(now));
      end else if (pick < 85) begin
        a = now - 48'($urandom_range(0, 60000));
        b = a + 48'($urandom_range(0, 80000));
        if ($urandom_range(0, 9) == 0) b = a - 48'($urandom_range(0, 5000));
        send_request(make_cmd(CMD_QUERY, a, b));
      end else if (pick < 97) begin
        send_request(make_cmd(CMD_TRIM, now - 48'($urandom_range(0, 20000)),
                              48'({$urandom, $urandom})));
      end else begin
        send_request(make_cmd(2'd3, 48'({$urandom, $urandom}), 48'({$urandom, $urandom})));
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    random_ready = 1'b0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    query_count = 0;
    ring_head = 0;
    ring_count = 0;
    window_reg = RETENTION_RESET;
    foreach (ring_time[i]) ring_time[i] = '0;
    foreach (ring_motion[i, j]) ring_motion[i][j] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    random_ready = 1'b1;
    test_ring_wrap();
    write_window(48'd0);
    test_random(20);
    write_window(48'hffff_ffff_ffff);
    test_random(15);
    write_window(48'd4000);
    test_random(20);
    // Hold off the sender until the unit has returned everything.
    drain();
    write_window(RETENTION_RESET);
    send_request(make_cmd(CMD_QUERY, 48'd0, 48'd1), 1'b0);

    drain();
    $display("Sent %0d requests including %0d queries; checked %0d returned samples.",
             request_count, query_count, result_count);
    $display("Covered ring wrap, trims under four retention windows and uncovered bounds.");
    if (error_count == 0) begin
      $display("** imu_sample_buffer_interpolator_unit: PASSED **");
    end else begin
      $display("** imu_sample_buffer_interpolator_unit: FAILED **");
    end
    $finish;
  end

endmodule
